@@ rtl/core/cfc_pkg.sv @@
package cfc_pkg;

  // Frame layout
  localparam int HDR_LEN      = 8;
  localparam int BODY_PID_OFS = 60;
  localparam int BODY_RID_OFS = 62;
  localparam int CMD_OFS      = 6;
  localparam int CMD_COUNT    = 9;
  localparam int SPEED_COUNT  = 3;
  localparam int PROTO_STEP   = 10000;

  // Verdict codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_ID_DIFF   = 3'd2;
  localparam logic [2:0] ST_PROTOCOL  = 3'd3;
  localparam logic [2:0] ST_BAD_SUM   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_PROTO_DIGIT    = 1'b0;
  localparam logic CFG_HANDSHAKE_DONE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               initial_request;
    logic signed [15:0] x_speed;
    logic signed [15:0] y_speed;
    logic signed [15:0] yaw_speed;
    logic [7:0]         enable_byte;
    logic [7:0]         mode_byte;
    logic [7:0]         emergency_byte;
    logic [15:0]        reset_commands;
    logic [15:0]        light_commands;
    logic [15:0]        setup_commands;
  } res_t;

  // Everything the verdict needs from one finished frame
  typedef struct packed {
    logic                             short_frame;
    logic [15:0]                      pid;
    logic [15:0]                      rid;
    logic [15:0]                      hdr_sum;
    logic [15:0]                      body_pid;
    logic [15:0]                      body_rid;
    logic [15:0]                      ones_sum;
    logic                             nonzero_seen;
    logic [SPEED_COUNT-1:0][15:0]     speed_words;
    logic [CMD_COUNT-1:0][7:0]        command_bytes;
  } frame_t;

endpackage

@@ rtl/core/command_frame_checker_top.sv @@
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | cfc_pkg::in_t  (data_byte, last_byte)
// out     | output    | out_valid/out_stall | cfc_pkg::res_t (status, initial_request, fields)
// cfg     | input     | cfg_we              | cfg_index selects register, cfg_data value
//
// One byte is taken per cycle while in_stall is low; the frame state updates in the same edge.
// A finished frame waits in a register until the result register can take it.
// The byte path stalls only while a finished frame cannot enter a full,
// stalled result register.
// Reset clears the frame state, the configuration and both valid flags.
module command_frame_checker_top #(
  parameter int BODY_BYTES       = 64,
  parameter int ZERO_CHECK_BYTES = 60
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cfc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cfc_pkg::res_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [2:0]    cfg_data
);
  import cfc_pkg::*;

  logic       proto_digit_lo;
  logic [2:0] proto_digit;
  logic       handshake_done;
  logic       take;
  logic       done_valid;
  frame_t     done;

  assign proto_digit_lo = proto_digit[0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      proto_digit    <= '0;
      handshake_done <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROTO_DIGIT:    proto_digit    <= cfg_data;
        CFG_HANDSHAKE_DONE: handshake_done <= cfg_data[0];
      endcase
    end
  end

  cfc_frame_acc #(
    .BODY_BYTES       (BODY_BYTES),
    .ZERO_CHECK_BYTES (ZERO_CHECK_BYTES)
  ) u_acc (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .done_valid (done_valid),
    .done       (done)
  );

  cfc_verdict u_verdict (
    .clk            (clk),
    .rst            (rst),
    .done_valid     (done_valid),
    .done           (done),
    .proto_digit    ({proto_digit[2:1], proto_digit_lo}),
    .handshake_done (handshake_done),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

@@ rtl/core/cfc_frame_acc.sv @@
module cfc_frame_acc #(
  parameter int BODY_BYTES       = 64,
  parameter int ZERO_CHECK_BYTES = 60
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cfc_pkg::in_t    in_data,
  input  logic            take,
  output logic            done_valid,
  output cfc_pkg::frame_t done
);
  import cfc_pkg::*;

  localparam int FRAME_LEN = HDR_LEN + BODY_BYTES;
  localparam int PW        = $clog2(FRAME_LEN + 1);
  localparam logic [PW-1:0] FRAME_END = PW'(FRAME_LEN);
  localparam logic [PW-1:0] HDR_END   = PW'(HDR_LEN);
  localparam logic [PW-1:0] ZERO_END  = PW'(ZERO_CHECK_BYTES);
  localparam logic [PW-1:0] BODY_LAST = PW'(BODY_BYTES - 1);

  logic [PW-1:0]                pos, pos_next;
  logic [15:0]                  ones_sum, ones_sum_next;
  logic [7:0]                   low_hold, low_hold_next;
  logic [15:0]                  pid, pid_next;
  logic [15:0]                  rid, rid_next;
  logic [15:0]                  hdr_sum, hdr_sum_next;
  logic [15:0]                  body_pid, body_pid_next;
  logic [15:0]                  body_rid, body_rid_next;
  logic                         nonzero_seen, nonzero_seen_next;
  logic [SPEED_COUNT-1:0][15:0] speed_words, speed_words_next;
  logic [CMD_COUNT-1:0][7:0]    command_bytes, command_bytes_next;

  logic          in_take;
  logic          in_frame;
  logic          in_hdr;
  logic          high_half;
  logic [PW-1:0] q;
  logic [15:0]   word;
  logic [15:0]   add_val;
  logic          do_add;
  logic [16:0]   sum_raw;
  frame_t        done_next;

  // Hold the byte only while a finished frame waits for the verdict stage
  assign in_stall = done_valid && !take;
  assign in_take  = in_valid && !in_stall;

  assign in_frame  = pos < FRAME_END;
  assign in_hdr    = pos < HDR_END;
  assign high_half = pos[0];
  assign q         = pos - HDR_END;
  assign word      = {in_data.data_byte, low_hold};

  // Ones'-complement add with end-around carry
  assign do_add  = in_frame && !in_hdr && (high_half || q == BODY_LAST);
  assign add_val = high_half ? word : {8'h00, in_data.data_byte};
  assign sum_raw = {1'b0, ones_sum} + {1'b0, add_val};

  // Next frame state for one byte
  always_comb begin
    pos_next           = pos;
    ones_sum_next      = ones_sum;
    low_hold_next      = low_hold;
    pid_next           = pid;
    rid_next           = rid;
    hdr_sum_next       = hdr_sum;
    body_pid_next      = body_pid;
    body_rid_next      = body_rid;
    nonzero_seen_next  = nonzero_seen;
    speed_words_next   = speed_words;
    command_bytes_next = command_bytes;
    if (in_frame) begin
      pos_next = pos + 1'b1;
      if (!high_half) begin
        low_hold_next = in_data.data_byte;
      end
      if (do_add) begin
        ones_sum_next = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end
      if (in_hdr) begin
        if (high_half) begin
          unique case (pos[2:1])
            2'd0:    pid_next     = word;
            2'd1:    rid_next     = word;
            2'd3:    hdr_sum_next = word;
            default: ;
          endcase
        end
      end else begin
        if (q < ZERO_END && in_data.data_byte != 8'h00) begin
          nonzero_seen_next = 1'b1;
        end
        for (int k = 0; k < CMD_COUNT; k++) begin
          if (q == PW'(CMD_OFS + k)) begin
            command_bytes_next[k] = in_data.data_byte;
          end
        end
        if (high_half) begin
          for (int k = 0; k < SPEED_COUNT; k++) begin
            if (q == PW'(2 * k + 1)) begin
              speed_words_next[k] = word;
            end
          end
          if (q == PW'(BODY_PID_OFS + 1)) begin
            body_pid_next = word;
          end
          if (q == PW'(BODY_RID_OFS + 1)) begin
            body_rid_next = word;
          end
        end
      end
    end
  end

  // Snapshot of the finished frame
  always_comb begin
    done_next.short_frame   = pos_next < FRAME_END;
    done_next.pid           = pid_next;
    done_next.rid           = rid_next;
    done_next.hdr_sum       = hdr_sum_next;
    done_next.body_pid      = body_pid_next;
    done_next.body_rid      = body_rid_next;
    done_next.ones_sum      = ones_sum_next;
    done_next.nonzero_seen  = nonzero_seen_next;
    done_next.speed_words   = speed_words_next;
    done_next.command_bytes = command_bytes_next;
  end

  // Advance frame state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      ones_sum      <= '0;
      low_hold      <= '0;
      pid           <= '0;
      rid           <= '0;
      hdr_sum       <= '0;
      body_pid      <= '0;
      body_rid      <= '0;
      nonzero_seen  <= 1'b0;
      speed_words   <= '0;
      command_bytes <= '0;
      done_valid    <= 1'b0;
    end else begin
      // Raise on a last byte, drop once the verdict stage takes the frame
      done_valid <= (done_valid && !take) || (in_take && in_data.last_byte);
      if (in_take) begin
        if (in_data.last_byte) begin
          pos           <= '0;
          ones_sum      <= '0;
          low_hold      <= '0;
          pid           <= '0;
          rid           <= '0;
          hdr_sum       <= '0;
          body_pid      <= '0;
          body_rid      <= '0;
          nonzero_seen  <= 1'b0;
          speed_words   <= '0;
          command_bytes <= '0;
        end else begin
          pos           <= pos_next;
          ones_sum      <= ones_sum_next;
          low_hold      <= low_hold_next;
          pid           <= pid_next;
          rid           <= rid_next;
          hdr_sum       <= hdr_sum_next;
          body_pid      <= body_pid_next;
          body_rid      <= body_rid_next;
          nonzero_seen  <= nonzero_seen_next;
          speed_words   <= speed_words_next;
          command_bytes <= command_bytes_next;
        end
      end
    end
  end

  // Capture the frame snapshot on its last byte
  always_ff @(posedge clk) begin
    if (in_take && in_data.last_byte) begin
      done <= done_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= FRAME_END)
    else $error("byte position ran past the frame length");

  a_done_kept: assert property (@(posedge clk) disable iff (rst)
    done_valid && !take |=> done_valid)
    else $error("finished frame dropped before the verdict stage took it");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_take && in_data.last_byte |=> done_valid && pos == '0 && ones_sum == '0)
    else $error("last byte did not close the frame");

endmodule

@@ rtl/core/cfc_verdict.sv @@
module cfc_verdict (
  input  logic            clk,
  input  logic            rst,
  input  logic            done_valid,
  input  cfc_pkg::frame_t done,
  input  logic [2:0]      proto_digit,
  input  logic            handshake_done,
  output logic            take,
  output logic            out_valid,
  input  logic            out_stall,
  output cfc_pkg::res_t   out_data
);
  import cfc_pkg::*;

  logic [16:0] proto_lo;
  logic [16:0] proto_hi;
  logic [16:0] pid_ext;
  logic        proto_match;
  logic [2:0]  status;
  logic        init_req;
  res_t        res_next;

  // Move the frame into the result register when it is empty or draining
  assign take = done_valid && (!out_valid || !out_stall);

  // Product id / 10000 == protocol digit, as a range check
  assign proto_lo    = 17'(proto_digit) * 17'(PROTO_STEP);
  assign proto_hi    = proto_lo + 17'(PROTO_STEP);
  assign pid_ext     = {1'b0, done.pid};
  assign proto_match = pid_ext >= proto_lo && pid_ext < proto_hi;

  // Checks in priority order
  always_comb begin
    if (done.short_frame) begin
      status = ST_SHORT;
    end else if (done.pid != done.body_pid || done.rid != done.body_rid) begin
      status = ST_ID_DIFF;
    end else if (!proto_match) begin
      status = ST_PROTOCOL;
    end else if (done.hdr_sum != ~done.ones_sum) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

  assign init_req = !handshake_done && !done.nonzero_seen;

  // Build the result; rejected frames and initial requests carry zero data
  always_comb begin
    res_next        = '0;
    res_next.status = status;
    if (status == ST_OK) begin
      res_next.initial_request = init_req;
      if (!init_req) begin
        res_next.x_speed        = done.speed_words[0];
        res_next.y_speed        = done.speed_words[1];
        res_next.yaw_speed      = done.speed_words[2];
        res_next.enable_byte    = done.command_bytes[0];
        res_next.mode_byte      = done.command_bytes[1];
        res_next.emergency_byte = done.command_bytes[2];
        res_next.reset_commands = {done.command_bytes[4], done.command_bytes[3]};
        res_next.light_commands = {done.command_bytes[6], done.command_bytes[5]};
        res_next.setup_commands = {done.command_bytes[8], done.command_bytes[7]};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res_next;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      !out_data.initial_request && out_data.x_speed == '0 &&
      out_data.enable_byte == '0 && out_data.setup_commands == '0)
    else $error("rejected frame carries data");

  a_init_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.initial_request |->
      out_data.status == ST_OK && out_data.yaw_speed == '0 &&
      out_data.mode_byte == '0 && out_data.light_commands == '0)
    else $error("initial request carries data or a reject code");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_BAD_SUM)
    else $error("undefined status code");

endmodule
